### hdl/rzn_pkg.sv
// ----------------------------------------------------------------------------
// rzn_pkg: shared constants and types for the row z-score normalizer
// Sample, result and accumulator widths, register indexes.
// ----------------------------------------------------------------------------
package rzn_pkg;
    localparam int ROW_MAX      = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int IDX_W        = $clog2(ROW_MAX);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SUM_W        = SAMPLE_WIDTH + IDX_W;
    localparam int SQ_W         = 2 * SAMPLE_WIDTH + IDX_W;
    localparam int D_W          = SQ_W + CNT_W;
    localparam int RAD_W        = D_W + 20 + ((D_W + 20) % 2);
    localparam int ROOT_W       = RAD_W / 2;
    localparam int NUM_W        = SUM_W + 2;
    localparam int DIVD_W       = NUM_W + 22;
    localparam int DIVS_W       = ROOT_W + 1;
    localparam int OUT_W        = 16;

    localparam logic [0:0] REG_ROW_LENGTH = 1'b0;
    localparam logic [0:0] REG_ROW_COUNT  = 1'b1;

    typedef struct packed {
        logic start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;
endpackage

### hdl/rzn_ram.sv
// ----------------------------------------------------------------------------
// rzn_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rzn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/rzn_divider.sv
// ----------------------------------------------------------------------------
// rzn_divider: restoring divider, one quotient bit per cycle
// Computes floor(dividend / divisor) bit-serially.
// ----------------------------------------------------------------------------
module rzn_divider
    (
    input  logic             clk,
    input  logic             rst_n,
    input  rzn_pkg::div_req_t req,
    output logic             done,
    output logic [rzn_pkg::DIVD_W-1:0] quotient
);
    import rzn_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = STEP_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### hdl/row_zscore_normalizer.sv
// ----------------------------------------------------------------------------
// row_zscore_normalizer: per-row z-score standardization
// Stores a row in RAM, then emits (x - mean) / std in Q4.11, saturated.
// ----------------------------------------------------------------------------
// A sample that does not close a row is simply stored (busy stays low).
// A closing sample starts the row pass: a multiply, a difference and
// a square root, then per element one RAM read, a numerator step and a
// bit-serial divide (skipped on a flat row); busy is high meanwhile.
// Results are strobed one cycle each; the receiver cannot stall.
// Reset clears counters, sums and control; the row RAM is not cleared.
module row_zscore_normalizer
    (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [rzn_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic signed [rzn_pkg::OUT_W-1:0] normalized,
    output logic        last_of_row,
    output logic        last_of_matrix,
    output logic        flat_row
);
    import rzn_pkg::*;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_MULT  = 7'b0000010,
        ST_DIFF  = 7'b0000100,
        ST_SQRT  = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_NUM   = 7'b0100000,
        ST_DIV   = 7'b1000000
    } state_t;

    localparam int SQ_STEPS = ROOT_W;
    localparam int SQC_W    = $clog2(SQ_STEPS + 1);

    state_t state_reg, state_next;
    logic [6:0]  row_length_reg;
    logic [15:0] row_count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [15:0]       rows_done_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [D_W-1:0]    nq_reg;
    logic [D_W-1:0]    ss_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+1:0] rrem_reg;
    logic [SQC_W-1:0]  sqc_reg;
    logic              flat_reg;
    logic              endm_reg;
    logic              neg_reg;

    logic [CNT_W-1:0]  n_eff;
    logic [15:0]       rc_eff;
    logic              accept;
    logic [SAMPLE_WIDTH-1:0] rd_data;
    logic signed [SUM_W-1:0]  sum_new;
    logic [SQ_W-1:0]          sq_new;
    logic signed [2*SAMPLE_WIDTH-1:0] xsq;
    logic [SUM_W-1:0]  s_abs;
    logic [ROOT_W+1:0] sq_trial;
    logic [ROOT_W+1:0] sq_rem;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]  num_mag;
    div_req_t          div_req;
    logic              div_done;
    logic [DIVD_W-1:0] quo;
    logic [DIVD_W-1:0] qr;
    logic signed [OUT_W-1:0] res;

    assign n_eff  = (row_length_reg == 7'd0) ? CNT_W'(1)
                  : (row_length_reg > 7'(ROW_MAX)) ? CNT_W'(ROW_MAX)
                  : CNT_W'(row_length_reg);
    assign rc_eff = (row_count_reg == 16'd0) ? 16'd1 : row_count_reg;

    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign xsq     = sample * sample;
    assign sum_new = sum_reg + SUM_W'(sample);
    assign sq_new  = sq_reg + SQ_W'(unsigned'(xsq));
    assign s_abs   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    rzn_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(ROW_MAX)) u_row_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (sample),
        .raddr (k_reg),
        .rdata (rd_data)
    );

    // one root bit per cycle: two radicand bits enter the remainder
    assign sq_trial = {rrem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_rem   = (ROOT_W+2)'({root_reg, 2'b01});
    assign num      = NUM_W'($signed({1'b0, n_reg})) * NUM_W'($signed(rd_data))
                    - NUM_W'(sum_reg);
    assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    assign div_req.start    = (state_reg == ST_NUM) && !flat_reg;
    assign div_req.dividend = DIVD_W'({num_mag, 22'd0}) + DIVD_W'(root_reg);
    assign div_req.divisor  = {root_reg, 1'b0};

    rzn_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quo)
    );

    assign qr = quo;
    always_comb
    begin
        if (flat_reg)
            res = '0;
        else if (neg_reg)
            res = (qr > DIVD_W'(32768)) ? OUT_W'(-32768) : OUT_W'(-qr);
        else
            res = (qr > DIVD_W'(32767)) ? OUT_W'(32767) : OUT_W'(qr);
    end

    logic emit;
    assign emit = (state_reg == ST_DIV && div_done) || (state_reg == ST_NUM && flat_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (accept && (count_reg + 1'b1 >= n_eff)) state_next = ST_MULT;
            ST_MULT: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQRT;
            ST_SQRT: if (sqc_reg == SQC_W'(1)) state_next = ST_READ;
            ST_READ: state_next = ST_NUM;
            ST_NUM:  state_next = flat_reg ?
                         ((k_reg == IDX_W'(n_reg - 1'b1)) ? ST_LOAD : ST_READ) : ST_DIV;
            ST_DIV:  if (div_done)
                         state_next = (k_reg == IDX_W'(n_reg - 1'b1)) ? ST_LOAD : ST_READ;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            row_length_reg <= 7'd64;
            row_count_reg  <= 16'd1;
            sum_reg        <= '0;
            sq_reg         <= '0;
            count_reg      <= '0;
            rows_done_reg  <= '0;
            k_reg          <= '0;
            sqc_reg        <= '0;
            result_valid   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= emit;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ROW_LENGTH: row_length_reg <= cfg_data[6:0];
                    REG_ROW_COUNT:  row_count_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                sum_reg   <= sum_new;
                sq_reg    <= sq_new;
                count_reg <= count_reg + 1'b1;
                if (count_reg + 1'b1 >= n_eff)
                begin
                    if (rows_done_reg + 1'b1 >= rc_eff)
                        rows_done_reg <= '0;
                    else
                        rows_done_reg <= rows_done_reg + 1'b1;
                end
            end
            if (state_reg == ST_DIFF)
                sqc_reg <= SQC_W'(SQ_STEPS);
            else if (state_reg == ST_SQRT)
                sqc_reg <= sqc_reg - 1'b1;
            if (state_reg == ST_SQRT)
                k_reg <= '0;
            else if (emit)
                k_reg <= k_reg + 1'b1;
            if (emit && k_reg == IDX_W'(n_reg - 1'b1))
            begin
                sum_reg   <= '0;
                sq_reg    <= '0;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (count_reg + 1'b1 >= n_eff))
        begin
            n_reg    <= count_reg + 1'b1;
            endm_reg <= (rows_done_reg + 1'b1 >= rc_eff);
        end
        if (state_reg == ST_MULT)
        begin
            nq_reg <= D_W'(n_reg) * D_W'(sq_reg);
            ss_reg <= D_W'(s_abs) * D_W'(s_abs);
        end
        if (state_reg == ST_DIFF)
        begin
            rad_reg  <= (nq_reg > ss_reg) ? RAD_W'({nq_reg - ss_reg, 20'd0}) : '0;
            flat_reg <= !(nq_reg > ss_reg);
            root_reg <= '0;
            rrem_reg <= '0;
        end
        if (state_reg == ST_SQRT)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (sq_trial >= sq_rem)
            begin
                rrem_reg <= sq_trial - sq_rem;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rrem_reg <= sq_trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_READ && root_reg == '0)
            flat_reg <= 1'b1;
        if (state_reg == ST_NUM)
        begin
            neg_reg <= num[NUM_W-1];
        end
        if (emit)
        begin
            normalized     <= res;
            last_of_row    <= (k_reg == IDX_W'(n_reg - 1'b1));
            last_of_matrix <= (k_reg == IDX_W'(n_reg - 1'b1)) && endm_reg;
            flat_row       <= flat_reg;
        end
    end

    // results only come out of a row pass
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result outside row pass");

    // no sample is taken while the row pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept)
        else $error("sample accepted while busy");

    // the end of a matrix is always the end of a row
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_matrix) |-> last_of_row)
        else $error("matrix end without row end");
endmodule

### dv/tb_row_zscore_normalizer.sv
// ----------------------------------------------------------------------------
// tb_row_zscore_normalizer: self-checking bench for the row z-score normalizer
// Drives samples and register writes with random gaps, predicts every
// normalized element, row and matrix end marks and the flat-row flag, and
// compares each strobed result against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_row_zscore_normalizer;
    import rzn_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] z;
        bit last_row;
        bit last_mat;
        bit flat;
    } zresult_t;

    class zscore_scoreboard;
        zresult_t pending[$];
        int errors;
        bit [6:0] len_reg;
        bit [15:0] rows_reg;
        longint store [ROW_MAX];
        longint sum;
        longint unsigned sq_sum;
        int count;
        int rows_done;

        function new();
            len_reg = 7'd64;
            rows_reg = 16'd1;
            sum = 0;
            sq_sum = 0;
            count = 0;
            rows_done = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [15:0] data);
            if (idx == REG_ROW_LENGTH)
                len_reg = data[6:0];
            else
                rows_reg = data;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // one accepted sample; a closing sample queues the whole row
        function void note_sample(logic signed [SAMPLE_WIDTH-1:0] x);
            int n_len;
            int n_rows;
            int n;
            longint unsigned nq;
            longint unsigned s_abs;
            longint unsigned dev;
            longint unsigned root;
            longint num;
            longint unsigned mag;
            longint unsigned q;
            bit flat;
            bit end_mat;
            zresult_t r;
            n_len = (len_reg == 0) ? 1 : ((len_reg > ROW_MAX) ? ROW_MAX : int'(len_reg));
            n_rows = (rows_reg == 0) ? 1 : int'(rows_reg);
            store[count % ROW_MAX] = longint'(x);
            sum += longint'(x);
            sq_sum += longint'(x) * longint'(x);
            count = (count % ROW_MAX) + 1;
            if (count < n_len)
                return;
            n = count;
            nq = longint'(n) * sq_sum;
            s_abs = (sum < 0) ? -sum : sum;
            dev = (nq > s_abs * s_abs) ? nq - s_abs * s_abs : 0;
            flat = (dev == 0);
            root = flat ? 0 : int_sqrt(dev << 20);
            if (root == 0)
                flat = 1;
            rows_done++;
            end_mat = (rows_done >= n_rows);
            if (end_mat)
                rows_done = 0;
            for (int k = 0; k < n; k++) begin
                r.z = '0;
                if (!flat) begin
                    num = longint'(n) * store[k] - sum;
                    mag = (num < 0) ? -num : num;
                    q = ((mag << 22) + root) / (2 * root);
                    if (num < 0)
                        r.z = (q > 32768) ? -16'sd32768 : OUT_W'(-longint'(q));
                    else
                        r.z = (q > 32767) ? 16'sd32767 : OUT_W'(q);
                end
                r.last_row = (k + 1 == n);
                r.last_mat = (k + 1 == n) && end_mat;
                r.flat = flat;
                pending.push_back(r);
            end
            sum = 0;
            sq_sum = 0;
            count = 0;
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic signed [OUT_W-1:0] z, logic lr, logic lm, logic fl);
            zresult_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result z=%0d", z));
                return;
            end
            e = pending.pop_front();
            if (z !== e.z)
                report($sformatf("normalized %0d, want %0d", z, e.z));
            if (lr !== e.last_row)
                report($sformatf("last_of_row %b, want %b", lr, e.last_row));
            if (lm !== e.last_mat)
                report($sformatf("last_of_matrix %b, want %b", lm, e.last_mat));
            if (fl !== e.flat)
                report($sformatf("flat_row %b, want %b", fl, e.flat));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [SAMPLE_WIDTH-1:0] sample = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = REG_ROW_LENGTH;
    logic [15:0] cfg_data = '0;
    logic result_valid;
    logic signed [OUT_W-1:0] normalized;
    logic last_of_row;
    logic last_of_matrix;
    logic flat_row;

    zscore_scoreboard sb = new();
    int random_sent;

    row_zscore_normalizer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .sample(sample),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .normalized(normalized),
        .last_of_row(last_of_row),
        .last_of_matrix(last_of_matrix),
        .flat_row(flat_row)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(normalized, last_of_row, last_of_matrix, flat_row);
    end

    task send_sample(logic signed [SAMPLE_WIDTH-1:0] x);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        sample <= x;
        do @(posedge clk); while (busy);
        sb.note_sample(x);
    endtask

    // quiesce: all results back, then cover the tail of the block's pass
    task settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task write_reg(logic [0:0] idx, logic [15:0] data);
        settle();
        repeat ($urandom_range(0, 18)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    function logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return SAMPLE_WIDTH'($urandom_range(0, 15) - 8);
            default: return SAMPLE_WIDTH'($urandom());
        endcase
    endfunction

    initial
    begin
        int len;
        int nrows;
        logic signed [SAMPLE_WIDTH-1:0] fixed;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // length-1 rows are always flat
        write_reg(REG_ROW_LENGTH, 16'd1);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sh0000);
        // extremes in a pair, then an equal pair
        write_reg(REG_ROW_LENGTH, 16'd2);
        write_reg(REG_ROW_COUNT, 16'd2);
        send_sample(-16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd5);
        send_sample(16'sd5);
        // zero length and zero count act as one
        write_reg(REG_ROW_LENGTH, 16'hFF80);
        write_reg(REG_ROW_COUNT, 16'd0);
        send_sample(16'sd300);
        send_sample(-16'sd1);
        // shorten a row midway: it closes at the next sample
        write_reg(REG_ROW_LENGTH, 16'd5);
        write_reg(REG_ROW_COUNT, 16'd3);
        send_sample(16'sd100);
        send_sample(-16'sd200);
        send_sample(16'sd7);
        write_reg(REG_ROW_LENGTH, 16'd2);
        send_sample(16'sd1);
        // lower the row count mid-matrix
        write_reg(REG_ROW_COUNT, 16'd1);
        send_sample(16'sd1000);
        send_sample(-16'sd999);

        random_sent = 0;
        while (random_sent < 160) begin
            case ($urandom_range(0, 9))
                0: len = 127;
                1: len = 64;
                2: len = $urandom_range(9, 63);
                default: len = $urandom_range(1, 8);
            endcase
            write_reg(REG_ROW_LENGTH, {9'($urandom_range(0, 511)), len[6:0]});
            case ($urandom_range(0, 7))
                0: write_reg(REG_ROW_COUNT, 16'hFFFF);
                1: write_reg(REG_ROW_COUNT, 16'd0);
                2: write_reg(REG_ROW_COUNT, 16'($urandom()));
                default: write_reg(REG_ROW_COUNT, 16'($urandom_range(1, 4)));
            endcase
            len = (len > ROW_MAX) ? ROW_MAX : len;
            nrows = (len > 16) ? 1 : $urandom_range(1, 4);
            fixed = pick_sample();
            for (int r = 0; r < nrows; r++) begin
                // some rows are constant to exercise the flat case
                bit constant_row;
                constant_row = ($urandom_range(0, 7) == 0);
                for (int k = 0; k < len; k++) begin
                    send_sample(constant_row ? fixed : pick_sample());
                    random_sent++;
                end
            end
        end

        settle();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(12 * 600000);
        $display("end of test: mismatches");
        $finish;
    end
endmodule
